// ===== hw/rtl/lcf_pkg.sv =====
// ============================================================================
// lcf_pkg
// Shared types, command codes, register opcodes and the segment ROM for the
// LED chain command framer.
// ============================================================================
package lcf_pkg;

    localparam int ROWS_PER_DEVICE = 8;

    localparam logic [3:0] CMD_LED       = 4'd0;
    localparam logic [3:0] CMD_ROW       = 4'd1;
    localparam logic [3:0] CMD_DIGIT     = 4'd2;
    localparam logic [3:0] CMD_CHAR      = 4'd3;
    localparam logic [3:0] CMD_CLEAR     = 4'd4;
    localparam logic [3:0] CMD_SHUTDOWN  = 4'd5;
    localparam logic [3:0] CMD_SCANLIMIT = 4'd6;
    localparam logic [3:0] CMD_INTENSITY = 4'd7;
    localparam logic [3:0] CMD_RAW       = 4'd8;
    localparam logic [3:0] CMD_REFRESH   = 4'd9;

    localparam logic [7:0] OPC_INTENSITY = 8'd10;
    localparam logic [7:0] OPC_SCANLIMIT = 8'd11;
    localparam logic [7:0] OPC_SHUTDOWN  = 8'd12;

    localparam logic [7:0] DP_BIT     = 8'b10000000;
    localparam logic [6:0] SPACE_CODE = 7'd32;

    typedef struct packed {
        logic load;
        logic rd_slot;
        logic modify;
        logic rd_word;
        logic emit;
    } lcf_ctrl_t;

    typedef struct packed {
        logic kind_none;
        logic multi;
        logic word_last;
        logic frame_last;
        logic out_free;
    } lcf_stat_t;

    function automatic logic [7:0] seg_rom(input logic [6:0] code);
        logic [7:0] seg;
        case (code)
            7'd0:    seg = 8'h7E;
            7'd1:    seg = 8'h06;
            7'd2:    seg = 8'h6D;
            7'd3:    seg = 8'h4F;
            7'd4:    seg = 8'h17;
            7'd5:    seg = 8'h5B;
            7'd6:    seg = 8'h7B;
            7'd7:    seg = 8'h0E;
            7'd8:    seg = 8'h7F;
            7'd9:    seg = 8'h5F;
            7'd10:   seg = 8'h3F;
            7'd11:   seg = 8'h73;
            7'd12:   seg = 8'h61;
            7'd13:   seg = 8'h67;
            7'd14:   seg = 8'h79;
            7'd15:   seg = 8'h39;
            7'd44:   seg = 8'h80;
            7'd45:   seg = 8'h01;
            7'd46:   seg = 8'h80;
            7'd48:   seg = 8'h7E;
            7'd49:   seg = 8'h30;
            7'd50:   seg = 8'h6D;
            7'd51:   seg = 8'h79;
            7'd52:   seg = 8'h33;
            7'd53:   seg = 8'h5B;
            7'd54:   seg = 8'h5F;
            7'd55:   seg = 8'h70;
            7'd56:   seg = 8'h7F;
            7'd57:   seg = 8'h7B;
            7'd65:   seg = 8'h77;
            7'd66:   seg = 8'h1F;
            7'd67:   seg = 8'h0D;
            7'd68:   seg = 8'h3D;
            7'd69:   seg = 8'h4F;
            7'd70:   seg = 8'h47;
            7'd72:   seg = 8'h37;
            7'd76:   seg = 8'h0E;
            7'd80:   seg = 8'h67;
            7'd95:   seg = 8'h08;
            7'd97:   seg = 8'h77;
            7'd98:   seg = 8'h1F;
            7'd99:   seg = 8'h0D;
            7'd100:  seg = 8'h3D;
            7'd101:  seg = 8'h4F;
            7'd102:  seg = 8'h47;
            7'd104:  seg = 8'h37;
            7'd108:  seg = 8'h0E;
            7'd110:  seg = 8'h15;
            7'd111:  seg = 8'h1D;
            7'd112:  seg = 8'h67;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== hw/rtl/lcf_ram.sv =====
// ============================================================================
// lcf_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module lcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lcf_datapath.sv =====
// ============================================================================
// lcf_datapath
// Command capture, frame store with per-entry valid bits, word assembly,
// frame and word counters, and the output register.
// ============================================================================
module lcf_datapath
    import lcf_pkg::*;
#(
    parameter int MAX_DEVICES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic [3:0]  command,
    input  logic [2:0]  device,
    input  logic [2:0]  position,
    input  logic [2:0]  column,
    input  logic [7:0]  value,
    input  logic [3:0]  reg_opcode,
    input  logic        flag,
    input  lcf_ctrl_t   ctrl,
    output lcf_stat_t   stat,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] chain_word,
    output logic        frame_end,
    output logic        last
);

    localparam int DEPTH  = MAX_DEVICES * ROWS_PER_DEVICE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [3:0]  cmd_reg;
    logic [2:0]  dev_reg;
    logic [2:0]  pos_reg;
    logic [2:0]  col_reg;
    logic [7:0]  val_reg;
    logic [3:0]  ropc_reg;
    logic        flag_reg;
    logic [7:0]  opc_reg;
    logic [7:0]  data_reg;
    logic [15:0] word_out_reg;
    logic        frame_end_reg;
    logic        last_reg;

    logic [3:0]       device_count_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             rd_vld_reg;
    logic [2:0]       frame_reg;
    logic [2:0]       frame_next;
    logic [2:0]       word_reg;
    logic [2:0]       word_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [3:0]        chain_len;
    logic              is_refresh;
    logic              is_clear;
    logic              dev_ok;
    logic              bad_cmd;
    logic              writes_store;
    logic [7:0]        rdata;
    logic [7:0]        cur_byte;
    logic [7:0]        led_mask;
    logic [6:0]        char_code;
    logic [7:0]        seg_byte;
    logic [7:0]        mod_opc;
    logic [7:0]        mod_data;
    logic [7:0]        frame_opc;
    logic [15:0]       word_data;
    logic              word_is_last;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign chain_len = (device_count_reg == 4'd0 || device_count_reg > 4'(MAX_DEVICES))
                       ? 4'(MAX_DEVICES) : device_count_reg;

    assign is_refresh   = (cmd_reg == CMD_REFRESH);
    assign is_clear     = (cmd_reg == CMD_CLEAR);
    assign dev_ok       = ({1'b0, dev_reg} < chain_len);
    assign writes_store = cmd_reg inside {CMD_LED, CMD_ROW, CMD_DIGIT, CMD_CHAR, CMD_CLEAR};

    always_comb
    begin
        case (cmd_reg)
            CMD_DIGIT:     bad_cmd = (val_reg > 8'd15);
            CMD_SCANLIMIT: bad_cmd = (val_reg > 8'd7);
            CMD_INTENSITY: bad_cmd = (val_reg > 8'd15);
            CMD_LED, CMD_ROW, CMD_CHAR, CMD_CLEAR, CMD_SHUTDOWN, CMD_RAW, CMD_REFRESH:
                           bad_cmd = 1'b0;
            default:       bad_cmd = 1'b1;
        endcase
    end

    assign cur_byte  = rd_vld_reg ? rdata : 8'h00;
    assign led_mask  = DP_BIT >> col_reg;
    assign char_code = val_reg[7] ? SPACE_CODE : val_reg[6:0];
    assign seg_byte  = seg_rom(char_code) | (flag_reg ? DP_BIT : 8'h00);

    always_comb
    begin
        mod_opc  = {5'd0, pos_reg} + 8'd1;
        mod_data = val_reg;
        case (cmd_reg)
            CMD_LED:       mod_data = flag_reg ? (cur_byte | led_mask) : (cur_byte & ~led_mask);
            CMD_ROW:       mod_data = val_reg;
            CMD_DIGIT:     mod_data = seg_byte;
            CMD_CHAR:      mod_data = seg_byte;
            CMD_CLEAR:     mod_data = 8'h00;
            CMD_SHUTDOWN:
            begin
                mod_opc  = OPC_SHUTDOWN;
                mod_data = {7'd0, ~flag_reg};
            end
            CMD_SCANLIMIT: mod_opc = OPC_SCANLIMIT;
            CMD_INTENSITY: mod_opc = OPC_INTENSITY;
            CMD_RAW:       mod_opc = {4'd0, ropc_reg};
            default:       mod_opc = {5'd0, pos_reg} + 8'd1;
        endcase
    end

    assign frame_opc = {5'd0, frame_reg} + 8'd1;

    always_comb
    begin
        if (is_refresh)
        begin
            word_data = {frame_opc, cur_byte};
        end
        else if (word_reg != dev_reg)
        begin
            word_data = 16'h0000;
        end
        else if (is_clear)
        begin
            word_data = {frame_opc, 8'h00};
        end
        else
        begin
            word_data = {opc_reg, data_reg};
        end
    end

    assign stat.kind_none  = !is_refresh && (!dev_ok || bad_cmd);
    assign stat.multi      = is_refresh || is_clear;
    assign stat.word_last  = (word_reg == 3'd0);
    assign stat.frame_last = (frame_reg == 3'(ROWS_PER_DEVICE - 1));
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign word_is_last = stat.word_last && (!stat.multi || stat.frame_last);

    assign ram_we = ctrl.modify && writes_store;
    assign ram_re = ctrl.rd_slot || ctrl.rd_word;
    assign waddr  = ADDR_W'({dev_reg, (is_clear ? frame_reg : pos_reg)});
    assign raddr  = ctrl.rd_word ? ADDR_W'({word_reg, frame_reg}) : ADDR_W'({dev_reg, pos_reg});

    lcf_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (mod_data),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    always_comb
    begin
        frame_next = frame_reg;
        word_next  = word_reg;
        if (ctrl.load)
        begin
            frame_next = 3'd0;
        end
        if (ctrl.modify)
        begin
            word_next = 3'(chain_len - 4'd1);
        end
        if (ctrl.emit)
        begin
            if (stat.word_last)
            begin
                frame_next = frame_reg + 3'd1;
            end
            else
            begin
                word_next = word_reg - 3'd1;
            end
        end
    end

    assign out_valid_next = ctrl.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_count_reg <= 4'd8;
            vld_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            frame_reg        <= 3'd0;
            word_reg         <= 3'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                device_count_reg <= cfg_data;
            end
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
            vld_reg       <= vld_next;
            frame_reg     <= frame_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            dev_reg  <= device;
            pos_reg  <= position;
            col_reg  <= column;
            val_reg  <= value;
            ropc_reg <= reg_opcode;
            flag_reg <= flag;
        end
        if (ctrl.modify)
        begin
            opc_reg  <= mod_opc;
            data_reg <= mod_data;
        end
        if (ctrl.emit)
        begin
            word_out_reg  <= word_data;
            frame_end_reg <= stat.word_last;
            last_reg      <= word_is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chain_word = word_out_reg;
    assign frame_end  = frame_end_reg;
    assign last       = last_reg;

endmodule

// ===== hw/rtl/lcf_ctrl.sv =====
// ============================================================================
// lcf_ctrl
// Sequencer for the LED chain command framer: accepts a command, runs the
// frame store update and steps through the frames and words it emits.
// ============================================================================
module lcf_ctrl
    import lcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  lcf_stat_t stat,
    output lcf_ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_MODIFY   = 3'd2;
    localparam logic [2:0] S_WORD_RD  = 3'd3;
    localparam logic [2:0] S_WORD_OUT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.kind_none)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.rd_slot = 1'b1;
                    state_next   = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                ctrl.modify = 1'b1;
                state_next  = S_WORD_RD;
            end
            S_WORD_RD:
            begin
                ctrl.rd_word = 1'b1;
                state_next   = S_WORD_OUT;
            end
            S_WORD_OUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.emit = 1'b1;
                    if (!stat.word_last)
                    begin
                        state_next = S_WORD_RD;
                    end
                    else if (stat.multi && !stat.frame_last)
                    begin
                        state_next = S_MODIFY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/led_chain_command_framer.sv =====
// ============================================================================
// led_chain_command_framer
// Turns display commands into 16-bit words for a daisy chain of 8x8 LED
// driver chips, keeping a frame store of eight row bytes per chip.
// ============================================================================
//
//  Channel  Handshake             Beat contents
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_stall   command, device, position, column, value,
//                                 reg_opcode, flag
//  out      out_valid / out_stall chain_word, frame_end, last
//  cfg      cfg_we                cfg_data (device count)
//
//  With N chips in the chain, a single-frame command emits N words, with one
//  frame store read per word; clear or refresh emits N words for each of the
//  eight rows. A command that emits nothing goes back to idle from decode.
//  Reset clears the per-entry valid bits at once, so the store reads as zero.
//  A stalled output word holds the sequencer; a new command is taken as soon
//  as the last word of the previous one sits in the output register.
//
module led_chain_command_framer
    import lcf_pkg::*;
#(
    parameter int MAX_DEVICES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  command,
    input  logic [2:0]  device,
    input  logic [2:0]  position,
    input  logic [2:0]  column,
    input  logic [7:0]  value,
    input  logic [3:0]  reg_opcode,
    input  logic        flag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] chain_word,
    output logic        frame_end,
    output logic        last
);

    lcf_ctrl_t ctrl;
    lcf_stat_t stat;

    lcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    lcf_datapath #(
        .MAX_DEVICES(MAX_DEVICES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .command    (command),
        .device     (device),
        .position   (position),
        .column     (column),
        .value      (value),
        .reg_opcode (reg_opcode),
        .flag       (flag),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .chain_word (chain_word),
        .frame_end  (frame_end),
        .last       (last)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a command but did not go busy");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> stat.out_free)
        else $error("word loaded over an output word not yet taken");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.rd_slot, ctrl.modify, ctrl.rd_word, ctrl.emit}))
        else $error("sequencer issued more than one datapath command");
`endif

endmodule
